[sv/spwq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spwq_pkg
// Shared types and codes of the sorted priority wait queue: the command and
// result payloads, the stored entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package spwq_pkg;

    localparam int ID_W      = 6;
    localparam int KEY_W     = 32;
    localparam int CNT_OUT_W = 7;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;

    localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_ID   = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_BADID    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [ID_W-1:0]         proc_id;
        logic signed [KEY_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]      out_id;
        logic [ST_W-1:0]      status;
        logic [CNT_OUT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
    } entry_t;

endpackage
`default_nettype wire

[sv/spwq_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spwq_store
// Entry memory of the queue: one write port, one read port, read data
// registered. Slot 0 is the head.
// ----------------------------------------------------------------------------
module spwq_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire spwq_pkg::entry_t         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output spwq_pkg::entry_t              rd_data
);

    spwq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[sv/sorted_priority_wait_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_wait_queue
// Wait queue of process ids kept sorted by signed priority, highest first,
// older entries ahead of newer ones among equal keys.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Its one result is
// shown on result for exactly one cycle with done high and cannot be held
// off. Commands that fail at once (full, bad id, empty) and an insert into
// an empty queue leave busy low and give their result in the next cycle.
// Otherwise the work walks the entry memory, one slot per cycle through its
// one read and one write port: an insert shifts each entry of lower key one
// slot toward the tail, then writes the new one; remove head and by id scan
// from the head and close the gap; remove tail drops the last entry.
// The result shows in the first cycle with busy low again.
// ----------------------------------------------------------------------------
module sorted_priority_wait_queue #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire spwq_pkg::cmd_t command,
    output logic                done,
    output spwq_pkg::rsp_t      result
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_INS0  = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic signed [spwq_pkg::KEY_W-1:0] key_reg, key_next;
    logic [spwq_pkg::ID_W-1:0] id_reg, id_next;
    logic [spwq_pkg::ID_W-1:0] rm_id_reg, rm_id_next;
    logic any_reg, any_next;
    logic done_reg, done_next;
    spwq_pkg::rsp_t result_reg, result_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    spwq_pkg::entry_t     wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    spwq_pkg::entry_t     rd_data;

    logic [CW-1:0]        ptr_plus1;
    logic                 bad_id;
    spwq_pkg::entry_t     new_entry;

    spwq_store #(
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ptr_plus1 = CW'(ptr_reg) + CW'(1);
    assign bad_id    = (32'(command.proc_id) >= MAX_ENTRIES);
    assign new_entry = '{key: key_reg, id: id_reg};

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        id_next     = id_reg;
        rm_id_next  = rm_id_reg;
        any_next    = any_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = command.priority_req;
                    id_next  = command.proc_id;
                    any_next = 1'b0;
                    result_next.out_id      = '0;
                    result_next.entry_count = spwq_pkg::CNT_OUT_W'(count_reg);
                    case (command.operation)
                        spwq_pkg::OP_INSERT:
                        begin
                            if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                done_next          = 1'b1;
                                result_next.status = spwq_pkg::ST_FULL;
                            end
                            else if (bad_id)
                            begin
                                done_next          = 1'b1;
                                result_next.status = spwq_pkg::ST_BADID;
                            end
                            else if (count_reg == '0)
                            begin
                                // first entry goes straight to the head
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = '{key: command.priority_req,
                                               id: command.proc_id};
                                count_next = CW'(1);
                                done_next  = 1'b1;
                                result_next.out_id      = command.proc_id;
                                result_next.status      = spwq_pkg::ST_OK;
                                result_next.entry_count = spwq_pkg::CNT_OUT_W'(CW'(1));
                            end
                            else
                            begin
                                // walk from the tail toward the head
                                ptr_next   = AW'(count_reg - CW'(1));
                                rd_en      = 1'b1;
                                rd_addr    = ptr_next;
                                state_next = S_INS;
                            end
                        end
                        spwq_pkg::OP_REMOVE_HEAD:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = spwq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                any_next   = 1'b1;
                                ptr_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_FIND;
                            end
                        end
                        spwq_pkg::OP_REMOVE_ID:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = spwq_pkg::ST_EMPTY;
                            end
                            else if (bad_id)
                            begin
                                done_next          = 1'b1;
                                result_next.status = spwq_pkg::ST_BADID;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = spwq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                any_next   = 1'b1;
                                ptr_next   = AW'(count_reg - CW'(1));
                                rd_en      = 1'b1;
                                rd_addr    = ptr_next;
                                state_next = S_FIND;
                            end
                        end
                    endcase
                end
            end

            S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_plus1);
                if (rd_data.key >= key_reg)
                begin
                    // new entry lands behind every key at or above its own
                    wr_data     = new_entry;
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    result_next = '{out_id: id_reg, status: spwq_pkg::ST_OK,
                                    entry_count: spwq_pkg::CNT_OUT_W'(count_reg + CW'(1))};
                    state_next  = S_IDLE;
                end
                else
                begin
                    // move this entry one slot toward the tail
                    wr_data = rd_data;
                    if (ptr_reg == '0)
                    begin
                        state_next = S_INS0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = ptr_next;
                    end
                end
            end

            S_INS0:
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = new_entry;
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                result_next = '{out_id: id_reg, status: spwq_pkg::ST_OK,
                                entry_count: spwq_pkg::CNT_OUT_W'(count_reg + CW'(1))};
                state_next  = S_IDLE;
            end

            S_FIND:
            begin
                if (any_reg || (rd_data.id == id_reg))
                begin
                    rm_id_next = rd_data.id;
                    if (ptr_plus1 < count_reg)
                    begin
                        ptr_next   = AW'(ptr_plus1);
                        rd_en      = 1'b1;
                        rd_addr    = ptr_next;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next  = count_reg - CW'(1);
                        done_next   = 1'b1;
                        result_next = '{out_id: rd_data.id, status: spwq_pkg::ST_OK,
                                        entry_count: spwq_pkg::CNT_OUT_W'(count_reg - CW'(1))};
                        state_next  = S_IDLE;
                    end
                end
                else if (ptr_plus1 == count_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{out_id: '0, status: spwq_pkg::ST_NOTFOUND,
                                    entry_count: spwq_pkg::CNT_OUT_W'(count_reg)};
                    state_next  = S_IDLE;
                end
                else
                begin
                    ptr_next = AW'(ptr_plus1);
                    rd_en    = 1'b1;
                    rd_addr  = ptr_next;
                end
            end

            S_SHIFT:
            begin
                // close the gap: move this entry one slot toward the head
                wr_en   = 1'b1;
                wr_addr = ptr_reg - AW'(1);
                wr_data = rd_data;
                if (ptr_plus1 < count_reg)
                begin
                    ptr_next = AW'(ptr_plus1);
                    rd_en    = 1'b1;
                    rd_addr  = ptr_next;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    result_next = '{out_id: rm_id_reg, status: spwq_pkg::ST_OK,
                                    entry_count: spwq_pkg::CNT_OUT_W'(count_reg - CW'(1))};
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        key_reg    <= key_next;
        id_reg     <= id_next;
        rm_id_reg  <= rm_id_next;
        any_reg    <= any_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
